@@ design/modular_exponentiation_defines.svh @@
// Assertion macros for the modular exponentiation block.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

`ifndef SYNTHESIS
`define MME_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define MME_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MME_ASSERT_SAME(lbl, ante, cons)
`define MME_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/mme_pkg.sv @@
// Shared constants and types for the modular exponentiation block.
// No dependencies.
package mme_pkg;

  localparam int FIELD_W   = 32;              // width of every payload field
  localparam int WIDTH     = 32;              // operand width, 8..32
  localparam int CNT_W     = $clog2(WIDTH);
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS  = 1'b0,
    REG_EXPONENT = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_START,
    ST_SQ,
    ST_SQ_END,
    ST_MUL,
    ST_MUL_END,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic start_sq;
    logic start_mul;
    logic step;
    logic commit;
    logic exp_shift;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic exp_msb;
  } dp_stat_t;

endpackage

@@ design/mme_stream_if.sv @@
// Request channel interfaces for the base input and the result output.
// Depends on mme_pkg.
interface mme_in_if;
  logic                        valid;
  logic                        ready;
  logic [mme_pkg::FIELD_W-1:0] base_value;

  modport source (output valid, output base_value, input ready);
  modport sink   (input valid, input base_value, output ready);
endinterface

interface mme_out_if;
  logic                        valid;
  logic                        ready;
  logic [mme_pkg::FIELD_W-1:0] power_result;
  logic                        bad_modulus;

  modport source (output valid, output power_result, output bad_modulus, input ready);
  modport sink   (input valid, input power_result, input bad_modulus, output ready);
endinterface

@@ design/modular_exponentiation.sv @@
// Channel    Dir  Payload                         Handshake
// in_ch      in   base_value[31:0]                valid/ready
// out_ch     out  power_result[31:0], bad_modulus valid/ready
// cfg_*      in   cfg_index selects modulus/exp   cfg_we, no wait
//
// One base at a time. Every exponent bit costs a squaring (ST_SQ_START, ST_SQ, ST_SQ_END)
// and a one bit a further multiply (ST_MUL, ST_MUL_END), each a pass of the bit-serial
// modular multiplier over all operand bits. A zero modulus goes straight to ST_DONE.
// rst_n is synchronous and clears the keys.
// A finished result sits in the output register while the next base is taken.
// Top level: configuration registers, controller and datapath.
// Depends on mme_pkg, mme_stream_if, mme_ctrl, mme_datapath, defines header.
`include "modular_exponentiation_defines.svh"

module modular_exponentiation (
  input  logic                          clk,
  input  logic                          rst_n,
  mme_in_if.sink                        in_ch,
  mme_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mme_pkg::FIELD_W-1:0]   cfg_wdata
);

  logic [mme_pkg::FIELD_W-1:0] modulus_r, exponent_r;
  mme_pkg::dp_cmd_t  cmd;
  mme_pkg::dp_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= '0;
      exponent_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == mme_pkg::REG_MODULUS) begin
        modulus_r <= cfg_wdata;
      end
      if (cfg_index == mme_pkg::REG_EXPONENT) begin
        exponent_r <= cfg_wdata;
      end
    end
  end

  mme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mme_datapath u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .stat      (stat),
    .mod_key   (modulus_r),
    .exp_key   (exponent_r),
    .base_in   (in_ch.base_value),
    .out_power (out_ch.power_result),
    .out_bad   (out_ch.bad_modulus)
  );

  `MME_ASSERT_NEXT(a_busy_after_req, in_ch.valid && in_ch.ready, !in_ch.ready)
  `MME_ASSERT_SAME(a_bad_gives_zero, out_ch.valid && out_ch.bad_modulus, out_ch.power_result == '0)
  `MME_ASSERT_SAME(a_result_after_work, $rose(out_ch.valid), !$past(in_ch.ready))
  `MME_ASSERT_SAME(a_load_only_idle, cmd.load, in_ch.ready && in_ch.valid)

endmodule

@@ design/mme_datapath.sv @@
// Datapath: operand registers and a bit-serial interleaved modular multiplier.
// Depends on mme_pkg; driven by mme_ctrl through dp_cmd_t.
module mme_datapath (
  input  logic                        clk,
  input  mme_pkg::dp_cmd_t            cmd,
  output mme_pkg::dp_stat_t           stat,
  input  logic [mme_pkg::FIELD_W-1:0] mod_key,
  input  logic [mme_pkg::FIELD_W-1:0] exp_key,
  input  logic [mme_pkg::FIELD_W-1:0] base_in,
  output logic [mme_pkg::FIELD_W-1:0] out_power,
  output logic                        out_bad
);

  localparam int W  = mme_pkg::WIDTH;
  localparam int SW = mme_pkg::WIDTH + 2;

  logic [W-1:0]  mod_r, exp_r, base_r, acc_r, prod_r, mplr_r;
  logic          zero_r;
  logic [mme_pkg::FIELD_W-1:0] out_power_r;
  logic          out_bad_r;

  logic [W-1:0]  mod_key_w;
  logic [SW-1:0] sum, m1, m2, red;

  assign mod_key_w = mod_key[W-1:0];

  // One multiplier bit per cycle: r = (2r + bit*acc) mod m, with r, acc < m.
  always_comb begin
    sum = {1'b0, prod_r, 1'b0} + (mplr_r[W-1] ? SW'(acc_r) : '0);
    m1  = SW'(mod_r);
    m2  = {1'b0, mod_r, 1'b0};
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_r  <= mod_key_w;
      exp_r  <= exp_key[W-1:0];
      base_r <= base_in[W-1:0];
      acc_r  <= (mod_key_w == W'(1)) ? '0 : W'(1);  // 1 mod m
      zero_r <= (mod_key_w == '0);
    end
    if (cmd.start_sq) begin
      mplr_r <= acc_r;
      prod_r <= '0;
    end
    if (cmd.start_mul) begin
      mplr_r <= base_r;
      prod_r <= '0;
    end
    if (cmd.step) begin
      prod_r <= red[W-1:0];
      mplr_r <= mplr_r << 1;
    end
    if (cmd.commit) begin
      acc_r <= prod_r;
    end
    if (cmd.exp_shift) begin
      exp_r <= exp_r << 1;
    end
    if (cmd.out_load) begin
      out_power_r <= zero_r ? '0 : mme_pkg::FIELD_W'(acc_r);
      out_bad_r   <= zero_r;
    end
  end

  assign stat.mod_zero = (mod_key_w == '0);
  assign stat.exp_msb  = exp_r[W-1];
  assign out_power     = out_power_r;
  assign out_bad       = out_bad_r;

endmodule

@@ design/mme_ctrl.sv @@
// Controller FSM: sequences squarings and multiplications over the exponent bits.
// Depends on mme_pkg; commands mme_datapath.
module mme_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  mme_pkg::dp_stat_t   stat,
  output mme_pkg::dp_cmd_t    cmd
);

  localparam int CW = mme_pkg::CNT_W;

  mme_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   ebit_r, ebit_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mme_pkg::ST_IDLE;
      cnt_r       <= '0;
      ebit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ebit_r      <= ebit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ebit_nxt      = ebit_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      mme_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          ebit_nxt = '0;
          state_nxt = stat.mod_zero ? mme_pkg::ST_DONE : mme_pkg::ST_SQ_START;
        end
      end
      mme_pkg::ST_SQ_START: begin
        cmd.start_sq = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = mme_pkg::ST_SQ;
      end
      mme_pkg::ST_SQ: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CW'(mme_pkg::WIDTH - 1)) begin
          state_nxt = mme_pkg::ST_SQ_END;
        end
      end
      mme_pkg::ST_SQ_END: begin
        cmd.commit = 1'b1;
        if (stat.exp_msb) begin
          cmd.start_mul = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = mme_pkg::ST_MUL;
        end else begin
          cmd.exp_shift = 1'b1;
          ebit_nxt      = ebit_r + 1'b1;
          state_nxt     = (ebit_r == CW'(mme_pkg::WIDTH - 1)) ? mme_pkg::ST_DONE
                                                                : mme_pkg::ST_SQ_START;
        end
      end
      mme_pkg::ST_MUL: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CW'(mme_pkg::WIDTH - 1)) begin
          state_nxt = mme_pkg::ST_MUL_END;
        end
      end
      mme_pkg::ST_MUL_END: begin
        cmd.commit    = 1'b1;
        cmd.exp_shift = 1'b1;
        ebit_nxt      = ebit_r + 1'b1;
        state_nxt     = (ebit_r == CW'(mme_pkg::WIDTH - 1)) ? mme_pkg::ST_DONE
                                                              : mme_pkg::ST_SQ_START;
      end
      mme_pkg::ST_DONE: begin
        // wait for the output slot to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = mme_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mme_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == mme_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
